// File: design/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and helpers for the segmentation confusion counter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int CNT_W             = 32;
  localparam int ROW_W             = 5;
  localparam int CLASS_W           = 8;
  localparam int MAX_CLASSES_DEF   = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [ROW_W-1:0] CLASS_COUNT_RESET = 5'd2;
  localparam logic [CNT_W-1:0] CNT_MAX           = '1;

  localparam logic ACT_COUNT   = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  typedef struct packed {
    logic               action;
    logic               in_mask;
    logic [CLASS_W-1:0] gold_class;
    logic [CLASS_W-1:0] test_class;
  } voxel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [CNT_W-1:0] true_pos;
    logic [CNT_W-1:0] true_neg;
    logic [CNT_W-1:0] false_pos;
    logic [CNT_W-1:0] false_neg;
    logic             last_row;
  } row_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic             readout;
    logic             match;
    logic             gold_ok;
    logic [ROW_W-1:0] gold_idx;
    logic             test_ok;
    logic [ROW_W-1:0] test_idx;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: design/scc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_front
// Accepts voxel requests, drops masked-out count requests and classifies the rest.
// ----------------------------------------------------------------------------
module scc_front (
  input  logic                    voxel_valid,
  output logic                    voxel_ready,
  input  scc_pkg::voxel_t         voxel,
  input  logic [scc_pkg::ROW_W-1:0] num_classes,
  input  logic                    q_full,
  output logic                    q_push,
  output scc_pkg::cmd_t           q_cmd
);

  logic [scc_pkg::CLASS_W-1:0] n_ext;

  assign n_ext       = {{(scc_pkg::CLASS_W-scc_pkg::ROW_W){1'b0}}, num_classes};
  assign voxel_ready = !q_full;
  // masked-out count requests are consumed without a queue entry
  assign q_push      = voxel_valid && !q_full &&
                       (voxel.action == scc_pkg::ACT_READOUT || voxel.in_mask);

  always_comb begin
    q_cmd.readout  = (voxel.action == scc_pkg::ACT_READOUT);
    q_cmd.match    = (voxel.gold_class == voxel.test_class);
    q_cmd.gold_ok  = (voxel.gold_class < n_ext);
    q_cmd.gold_idx = voxel.gold_class[scc_pkg::ROW_W-1:0];
    q_cmd.test_ok  = (voxel.test_class < n_ext);
    q_cmd.test_idx = voxel.test_class[scc_pkg::ROW_W-1:0];
  end

endmodule

// File: design/scc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module scc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output scc_pkg::cmd_t head_cmd
);

  localparam int DEPTH = scc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scc_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");

endmodule

// File: design/scc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_back
// Per-class counter lanes, overall totals and the row read-out sequencer.
// ----------------------------------------------------------------------------
module scc_back #(
  parameter int MAX_CLASSES = scc_pkg::MAX_CLASSES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [scc_pkg::ROW_W-1:0] num_classes,
  input  logic                      cmd_valid,
  input  scc_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      row_valid,
  input  logic                      row_ready,
  output scc_pkg::row_t             row
);

  localparam int CLS_W = $clog2(MAX_CLASSES);

  logic [scc_pkg::CNT_W-1:0] tp [MAX_CLASSES];
  logic [scc_pkg::CNT_W-1:0] tn [MAX_CLASSES];
  logic [scc_pkg::CNT_W-1:0] fp [MAX_CLASSES];
  logic [scc_pkg::CNT_W-1:0] fn [MAX_CLASSES];
  logic [scc_pkg::CNT_W-1:0] total_match;
  logic [scc_pkg::CNT_W-1:0] total_mismatch;

  logic [scc_pkg::ROW_W-1:0] rd_row;
  logic [CLS_W-1:0]          lane_sel;
  logic                      slot_free;
  logic                      exec_count;
  logic                      exec_read;
  logic                      read_last;

  assign slot_free  = !row_valid || row_ready;
  assign exec_count = cmd_valid && !cmd.readout;
  assign exec_read  = cmd_valid && cmd.readout && slot_free;
  assign read_last  = exec_read && (rd_row == num_classes);
  assign cmd_pop    = exec_count || read_last;
  assign lane_sel   = CLS_W'(rd_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row <= '0;
    end else if (read_last) begin
      rd_row <= '0;
    end else if (exec_read) begin
      rd_row <= rd_row + 1'b1;
    end
  end

  for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_lane
    logic active;
    logic is_gold;
    logic is_test;

    assign active  = (g < int'(num_classes));
    assign is_gold = cmd.gold_ok && (int'(cmd.gold_idx) == g);
    assign is_test = cmd.test_ok && (int'(cmd.test_idx) == g);

    always_ff @(posedge clk) begin
      if (rst || read_last) begin
        tp[g] <= '0;
        tn[g] <= '0;
        fp[g] <= '0;
        fn[g] <= '0;
      end else if (exec_count && active) begin
        if (cmd.match) begin
          if (is_gold) tp[g] <= scc_pkg::sat_inc(tp[g]);
          else         tn[g] <= scc_pkg::sat_inc(tn[g]);
        end else begin
          priority if (is_gold) fn[g] <= scc_pkg::sat_inc(fn[g]);
          else if (is_test)     fp[g] <= scc_pkg::sat_inc(fp[g]);
          else                  tn[g] <= scc_pkg::sat_inc(tn[g]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || read_last) begin
      total_match    <= '0;
      total_mismatch <= '0;
    end else if (exec_count) begin
      if (cmd.match) total_match    <= scc_pkg::sat_inc(total_match);
      else           total_mismatch <= scc_pkg::sat_inc(total_mismatch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (exec_read) begin
      row_valid <= 1'b1;
    end else if (row_ready) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_read) begin
      row.row_index <= rd_row;
      if (read_last) begin
        row.true_pos  <= total_match;
        row.true_neg  <= '0;
        row.false_pos <= total_mismatch;
        row.false_neg <= total_mismatch;
        row.last_row  <= 1'b1;
      end else begin
        row.true_pos  <= tp[lane_sel];
        row.true_neg  <= tn[lane_sel];
        row.false_pos <= fp[lane_sel];
        row.false_neg <= fn[lane_sel];
        row.last_row  <= 1'b0;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
      read_last |=> (total_match == '0 && total_mismatch == '0))
    else $error("totals not cleared after read-out");
  a_row_bound: assert property (@(posedge clk) disable iff (rst) rd_row <= num_classes)
    else $error("read-out row past class count");
  a_no_count_mid_readout: assert property (@(posedge clk) disable iff (rst)
      (rd_row != '0) |-> !exec_count)
    else $error("count executed during read-out");

endmodule

// File: design/segmentation_confusion_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmentation_confusion_counter_unit
// One-vs-rest confusion counters per class with overall match totals.
//
//   channel      signals                          direction
//   voxel        voxel_valid/voxel_ready/voxel    in   (voxel_t)
//   row          row_valid/row_ready/row          out  (row_t)
//   class_count  class_count_we/class_count_wdata in   (write only)
//
// Count requests: one per cycle unless a read-out holds the queue head; each is
// counted at the edge that pops it from the queue.
// Read-out: effective class count + 1 rows, one per cycle while row_ready is
// high, limited by the single output register; counts queued behind it wait
// until the overall row loads.
// Reset (rst, synchronous) clears counters, queue and row_valid; class_count = 2.
// Stalls on row_ready fill the 4-entry queue, then drop voxel_ready.
// ----------------------------------------------------------------------------
module segmentation_confusion_counter_unit #(
  parameter int MAX_CLASSES = scc_pkg::MAX_CLASSES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      class_count_we,
  input  logic [scc_pkg::ROW_W-1:0] class_count_wdata,
  input  logic                      voxel_valid,
  output logic                      voxel_ready,
  input  scc_pkg::voxel_t           voxel,
  output logic                      row_valid,
  input  logic                      row_ready,
  output scc_pkg::row_t             row
);

  logic [scc_pkg::ROW_W-1:0] class_count;
  logic [scc_pkg::ROW_W-1:0] num_classes;
  logic                      q_full;
  logic                      q_push;
  scc_pkg::cmd_t             q_cmd;
  logic                      head_valid;
  scc_pkg::cmd_t             head_cmd;
  logic                      cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= scc_pkg::CLASS_COUNT_RESET;
    end else if (class_count_we) begin
      class_count <= class_count_wdata;
    end
  end

  // effective count, limited to the lanes that exist
  assign num_classes = (int'(class_count) > MAX_CLASSES) ?
                       scc_pkg::ROW_W'(MAX_CLASSES) : class_count;

  scc_front u_front (
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .voxel       (voxel),
    .num_classes (num_classes),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  scc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  scc_back #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .num_classes (num_classes),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .row_valid   (row_valid),
    .row_ready   (row_ready),
    .row         (row)
  );

endmodule
